// File: rtl/lztsd_pkg.sv
package lztsd_pkg;

  localparam int HIST_DEPTH  = 65536;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int CNT_W       = HIST_AW + 1;
  localparam int LEN_W       = 32;
  localparam int DIST_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [7:0] BYTE_MAX   = 8'hFF;
  localparam logic [3:0] NIBBLE_MAX = 4'hF;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_NO_PULL = 3'd2;
  localparam logic [2:0] ST_BAD_OFF = 3'd3;
  localparam logic [2:0] ST_OVF     = 3'd4;
  localparam logic [2:0] ST_TRUNC   = 3'd5;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
    logic       copy_pending;
    logic       seq_end;
  } out_t;

  typedef struct packed {
    logic               wr;
    logic               copy;
    logic [7:0]         lit_byte;
    logic [HIST_AW-1:0] rd_addr;
    logic [HIST_AW-1:0] wr_addr;
    logic [2:0]         status;
    logic               copy_pending;
    logic               seq_end;
  } op_t;

endpackage

// File: rtl/lztsd_front.sv
module lztsd_front
  import lztsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  in_t  item,
  output op_t  op
);

  localparam logic [2:0] PH_TOKEN     = 3'd0;
  localparam logic [2:0] PH_LIT_EXT   = 3'd1;
  localparam logic [2:0] PH_OFF_LO    = 3'd2;
  localparam logic [2:0] PH_OFF_HI    = 3'd3;
  localparam logic [2:0] PH_MATCH_EXT = 3'd4;
  localparam logic [2:0] PH_LITERALS  = 3'd5;
  localparam logic [2:0] PH_COPY      = 3'd6;

  logic [2:0]         phase, phase_next;
  logic [LEN_W-1:0]   lit_rem, lit_next;
  logic [LEN_W-1:0]   match_rem, match_next;
  logic [DIST_W-1:0]  back_dist, back_dist_next;
  logic [HIST_AW-1:0] wp, wp_next, wp_inc;
  logic [CNT_W-1:0]   prod, prod_next, prod_inc;
  logic [LEN_W:0]     lit_sum, match_sum;
  logic               do_header, do_start, ovf;

  assign wp_inc    = wp + 1'b1;
  assign prod_inc  = (prod == CNT_W'(HIST_DEPTH)) ? prod : prod + 1'b1;
  assign lit_sum   = {1'b0, lit_rem} + (LEN_W+1)'(item.in_byte);
  assign match_sum = {1'b0, match_rem} + (LEN_W+1)'(item.in_byte);

  always_comb begin
    phase_next     = phase;
    lit_next       = lit_rem;
    match_next     = match_rem;
    back_dist_next = back_dist;
    wp_next        = wp;
    prod_next      = prod;
    op             = '0;
    op.wr_addr     = wp;
    do_header      = 1'b0;
    do_start       = 1'b0;
    ovf            = 1'b0;
    if (item.cmd) begin
      if (phase == PH_COPY && match_rem != '0) begin
        op.copy    = 1'b1;
        op.wr      = 1'b1;
        op.rd_addr = wp - HIST_AW'(back_dist);
        wp_next    = wp_inc;
        prod_next  = prod_inc;
        match_next = match_rem - 1'b1;
        if (match_next == '0) begin
          op.seq_end = 1'b1;
          phase_next = PH_TOKEN;
        end
      end else begin
        op.status = ST_NO_PULL;
      end
    end else if (phase == PH_COPY) begin
      op.status = ST_REFUSED;
    end else begin
      unique case (phase)
        PH_LIT_EXT: begin
          if (lit_sum[LEN_W]) begin
            lit_next = '1;
            ovf      = 1'b1;
          end else begin
            lit_next = lit_sum[LEN_W-1:0];
          end
          if (item.in_byte != BYTE_MAX) phase_next = PH_OFF_LO;
        end
        PH_OFF_LO: begin
          back_dist_next = DIST_W'(item.in_byte);
          phase_next     = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          back_dist_next = {item.in_byte, back_dist[7:0]};
          if (match_rem == LEN_W'(NIBBLE_MAX)) phase_next = PH_MATCH_EXT;
          else do_header = 1'b1;
        end
        PH_MATCH_EXT: begin
          if (match_sum[LEN_W]) begin
            match_next = '1;
            ovf        = 1'b1;
          end else begin
            match_next = match_sum[LEN_W-1:0];
          end
          if (item.in_byte != BYTE_MAX) do_header = 1'b1;
        end
        PH_LITERALS: begin
          op.wr       = 1'b1;
          op.lit_byte = item.in_byte;
          wp_next     = wp_inc;
          prod_next   = prod_inc;
          if (lit_rem != '0) lit_next = lit_rem - 1'b1;
          if (lit_next == '0) do_start = 1'b1;
        end
        default: begin
          lit_next       = LEN_W'(item.in_byte[7:4]);
          match_next     = LEN_W'(item.in_byte[3:0]);
          back_dist_next = '0;
          phase_next = (item.in_byte[7:4] == NIBBLE_MAX) ? PH_LIT_EXT : PH_OFF_LO;
        end
      endcase
      if (do_header) begin
        if (lit_next != '0) phase_next = PH_LITERALS;
        else do_start = 1'b1;
      end
      if (do_start) begin
        if (match_next == '0) begin
          op.seq_end = 1'b1;
          phase_next = PH_TOKEN;
        end else if (back_dist_next == '0 ||
                     {1'b0, back_dist_next} > (DIST_W+1)'(prod_next)) begin
          op.status  = ST_BAD_OFF;
          op.seq_end = 1'b1;
          match_next = '0;
          phase_next = PH_TOKEN;
        end else begin
          phase_next = PH_COPY;
        end
      end
      if (ovf) op.status = ST_OVF;
      if (item.last_byte && phase_next != PH_TOKEN && phase_next != PH_COPY) begin
        op.status  = ST_TRUNC;
        phase_next = PH_TOKEN;
        lit_next   = '0;
        match_next = '0;
      end
    end
    op.copy_pending = (phase_next == PH_COPY) && (match_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TOKEN;
      lit_rem   <= '0;
      match_rem <= '0;
      back_dist <= '0;
      wp        <= '0;
      prod      <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      lit_rem   <= lit_next;
      match_rem <= match_next;
      back_dist <= back_dist_next;
      wp        <= wp_next;
      prod      <= prod_next;
    end
  end

endmodule

// File: rtl/lztsd_queue.sv
module lztsd_queue
  import lztsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/lztsd_back.sv
module lztsd_back
  import lztsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  op_t  head_op,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [7:0] hist [HIST_DEPTH];
  logic [7:0] mem_q;
  op_t        b_op;
  logic       b_valid;
  logic       fwd_hit;
  logic [7:0] fwd_byte;
  logic [7:0] b_byte;
  logic       out_free, b_adv, b_ready;

  assign out_free = !out_valid || out_ready;
  assign b_adv    = b_valid && out_free;
  assign b_ready  = !b_valid || out_free;
  assign pop      = head_valid && b_ready;
  assign b_byte   = b_op.copy ? (fwd_hit ? fwd_byte : mem_q) : b_op.lit_byte;

  // history: read on issue, write when the op retires to the output register
  always_ff @(posedge clk) begin
    if (pop) mem_q <= hist[head_op.rd_addr];
    if (b_adv && b_op.wr) hist[b_op.wr_addr] <= b_byte;
  end

  // the retiring op's byte is not yet in memory when the next op reads
  always_ff @(posedge clk) begin
    if (pop) begin
      b_op     <= head_op;
      fwd_hit  <= b_valid && b_op.wr && (b_op.wr_addr == head_op.rd_addr);
      fwd_byte <= b_byte;
    end
    if (b_adv) begin
      out_data.out_byte     <= b_op.wr ? b_byte : 8'd0;
      out_data.out_valid    <= b_op.wr;
      out_data.status       <= b_op.status;
      out_data.copy_pending <= b_op.copy_pending;
      out_data.seq_end      <= b_op.seq_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) b_valid <= 1'b1;
      else if (b_adv) b_valid <= 1'b0;
      if (b_adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/lz_token_sequence_decompressor.sv
// an input's op passes the queue, the back-stage register and the output register
// one item per cycle while out_ready holds, incl. back-to-back overlapping match copies
// the history memory takes one read and one write per cycle, set by the back stage
// a 4-entry op queue decouples the decoder front from the history back end
// reset (rst, synchronous) clears decoder state, queue and output; history is not cleared
module lz_token_sequence_decompressor
  import lztsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic accept;
  op_t  front_op;
  op_t  head_op;
  logic q_full, q_pop, q_head_valid;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  lztsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .op     (front_op)
  );

  lztsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (head_op)
  );

  lztsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.out_valid |-> out_data.out_byte == 8'd0)
    else $error("byte not zero on a result without data");

  a_pull_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_NO_PULL |->
      !out_data.out_valid && !out_data.seq_end)
    else $error("empty pull produced data or ended a sequence");

  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_REFUSED |->
      !out_data.out_valid && out_data.copy_pending)
    else $error("refused byte without a pending copy");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_TRUNC)
    else $error("status code out of range");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import lztsd_pkg::*;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_PULL = 1'b1;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_WAIT = 13;
  localparam int STREAM_ITEMS = 530;

  typedef enum logic [2:0] {
    S_TOKEN, S_LIT_EXT, S_OFF_LO, S_OFF_HI, S_MATCH_EXT, S_LITERALS, S_COPY
  } dec_phase_e;

  typedef struct {
    in_t item;
    bit  hold;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  lz_token_sequence_decompressor dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as predicted
  dec_phase_e         ph = S_TOKEN;
  logic [LEN_W-1:0]   lit_left = '0;
  logic [LEN_W-1:0]   match_left = '0;
  logic [DIST_W-1:0]  back_dist = '0;
  logic [HIST_AW-1:0] wr_ptr = '0;
  logic [CNT_W-1:0]   hist_count = '0;
  logic [7:0]         hist_mem [HIST_DEPTH];

  stream_item_t stream_q[$];
  out_t         decoded_q[$];

  int hist_fill_est = 0;
  int mismatches = 0;
  int n_sent = 0, n_results = 0;
  int n_literal = 0, n_copied = 0, n_trunc = 0, n_badoff = 0;
  int n_refused = 0, n_nopull = 0, n_seq_end = 0;
  int idle_cycles = 0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic store_byte(input logic [7:0] b);
    hist_mem[wr_ptr] = b;
    wr_ptr++;
    if (hist_count < HIST_DEPTH) hist_count++;
  endtask

  task automatic grow_len(inout logic [LEN_W-1:0] len, input logic [7:0] b, inout logic ovf);
    logic [LEN_W:0] sum;
    sum = {1'b0, len} + (LEN_W+1)'(b);
    if (sum[LEN_W]) begin
      len = '1;
      ovf = 1'b1;
    end else begin
      len = sum[LEN_W-1:0];
    end
  endtask

  task automatic begin_match(inout out_t r);
    if (match_left == 0) begin
      r.seq_end = 1'b1;
      ph = S_TOKEN;
    end else if (back_dist == 0 || back_dist > hist_count) begin
      r.status = ST_BAD_OFF;
      r.seq_end = 1'b1;
      match_left = '0;
      ph = S_TOKEN;
      n_badoff++;
    end else begin
      ph = S_COPY;
    end
  endtask

  task automatic decode_step(input in_t it);
    out_t r;
    logic ovf;
    logic [HIST_AW-1:0] rd;
    r = '0;
    ovf = 1'b0;
    if (it.cmd == CMD_PULL) begin
      if (ph == S_COPY && match_left != 0) begin
        rd = wr_ptr - back_dist;
        r.out_byte = hist_mem[rd];
        r.out_valid = 1'b1;
        store_byte(r.out_byte);
        match_left--;
        n_copied++;
        if (match_left == 0) begin
          r.seq_end = 1'b1;
          ph = S_TOKEN;
        end
      end else begin
        r.status = ST_NO_PULL;
        n_nopull++;
      end
    end else if (ph == S_COPY) begin
      r.status = ST_REFUSED;
      n_refused++;
    end else begin
      case (ph)
        S_LIT_EXT: begin
          grow_len(lit_left, it.in_byte, ovf);
          if (it.in_byte != BYTE_MAX) ph = S_OFF_LO;
        end
        S_OFF_LO: begin
          back_dist = {8'h00, it.in_byte};
          ph = S_OFF_HI;
        end
        S_OFF_HI: begin
          back_dist[15:8] = it.in_byte;
          if (match_left == NIBBLE_MAX) ph = S_MATCH_EXT;
          else if (lit_left != 0) ph = S_LITERALS;
          else begin_match(r);
        end
        S_MATCH_EXT: begin
          grow_len(match_left, it.in_byte, ovf);
          if (it.in_byte != BYTE_MAX) begin
            if (lit_left != 0) ph = S_LITERALS;
            else begin_match(r);
          end
        end
        S_LITERALS: begin
          r.out_byte = it.in_byte;
          r.out_valid = 1'b1;
          store_byte(it.in_byte);
          n_literal++;
          if (lit_left != 0) lit_left--;
          if (lit_left == 0) begin_match(r);
        end
        default: begin
          lit_left = LEN_W'(it.in_byte[7:4]);
          match_left = LEN_W'(it.in_byte[3:0]);
          back_dist = '0;
          ph = (it.in_byte[7:4] == NIBBLE_MAX) ? S_LIT_EXT : S_OFF_LO;
        end
      endcase
      if (ovf) r.status = ST_OVF;
      if (it.last_byte && ph != S_TOKEN && ph != S_COPY) begin
        r.status = ST_TRUNC;
        ph = S_TOKEN;
        lit_left = '0;
        match_left = '0;
        n_trunc++;
      end
    end
    r.copy_pending = (ph == S_COPY && match_left != 0);
    if (r.seq_end) n_seq_end++;
    decoded_q.push_back(r);
  endtask

  task automatic add_item(input logic cmd, input logic [7:0] b, input logic last, input bit hold);
    stream_item_t s;
    s.item.cmd = cmd;
    s.item.in_byte = b;
    s.item.last_byte = last;
    s.hold = hold;
    stream_q.push_back(s);
  endtask

  task automatic push_ext(ref logic [7:0] q[$], input int rem);
    while (rem >= 255) begin
      q.push_back(BYTE_MAX);
      rem -= 255;
    end
    q.push_back(8'(rem));
  endtask

  function automatic int pick_len(input bit big_ok);
    int r;
    r = $urandom_range(0, 99);
    if (big_ok && r < 20) return $urandom_range(255, 560);
    if (r < 28) return $urandom_range(15, 40);
    return $urandom_range(0, 16);
  endfunction

  // cut: -1 keeps the whole sequence, -2 picks a random cut point, else byte index
  task automatic add_sequence(input int lits, input int mlen, input int dist_v,
                              input bit end_last, input int cut, input bit hold);
    logic [7:0] seq_bytes[$];
    int hdr, n_lit, avail, hi;
    bit ok;
    seq_bytes.push_back({(lits >= 15) ? NIBBLE_MAX : 4'(lits),
                         (mlen >= 15) ? NIBBLE_MAX : 4'(mlen)});
    if (lits >= 15) push_ext(seq_bytes, lits - 15);
    seq_bytes.push_back(dist_v[7:0]);
    seq_bytes.push_back(dist_v[15:8]);
    if (mlen >= 15) push_ext(seq_bytes, mlen - 15);
    hdr = seq_bytes.size();
    repeat (lits) seq_bytes.push_back(8'($urandom));
    if (cut == -2) begin
      hi = (seq_bytes.size() - 2 < hdr + 4) ? seq_bytes.size() - 2 : hdr + 4;
      cut = $urandom_range(0, hi);
    end
    if (cut >= 0 && cut < seq_bytes.size() - 1) begin
      while (seq_bytes.size() > cut + 1) void'(seq_bytes.pop_back());
      n_lit = seq_bytes.size() - hdr;
      if (n_lit > 0) hist_fill_est += n_lit;
      foreach (seq_bytes[i])
        add_item(CMD_BYTE, seq_bytes[i], i == seq_bytes.size() - 1, hold && i == 0);
      return;
    end
    avail = hist_fill_est + lits;
    ok = mlen != 0 && dist_v != 0 && dist_v <= avail;
    foreach (seq_bytes[i])
      add_item(CMD_BYTE, seq_bytes[i], end_last && i == seq_bytes.size() - 1,
               hold && i == 0);
    if (ok) begin
      repeat (mlen) begin
        if ($urandom_range(0, 15) == 0)
          add_item(CMD_BYTE, 8'($urandom), 1'($urandom), 1'b0);
        add_item(CMD_PULL, 8'($urandom), 1'($urandom), 1'b0);
      end
    end
    if ($urandom_range(0, 7) == 0) add_item(CMD_PULL, 8'($urandom), 1'($urandom), 1'b0);
    hist_fill_est += lits + (ok ? mlen : 0);
    if (hist_fill_est > HIST_DEPTH) hist_fill_est = HIST_DEPTH;
  endtask

  // sender
  int  send_wait = 0;
  bit  send_calm = 1'b0;

  always @(posedge clk) begin : drive
    stream_item_t nxt;
    if (!rst) begin
      if (in_valid && in_ready) begin
        decode_step(in_data);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0 && !(stream_q[0].hold && decoded_q.size() != 0)) begin
          nxt = stream_q.pop_front();
          in_data <= nxt.item;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_wait <= send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int  recv_wait = 0;
  bit  recv_calm = 1'b0;

  always @(posedge clk) begin : observe
    out_t want;
    int w;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      n_results++;
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no transfer pending", n_results));
      end else begin
        want = decoded_q.pop_front();
        if (out_data.out_byte !== want.out_byte)
          flag_mismatch($sformatf("result %0d out_byte %h, want %h",
                                  n_results, out_data.out_byte, want.out_byte));
        if (out_data.out_valid !== want.out_valid)
          flag_mismatch($sformatf("result %0d out_valid %b, want %b",
                                  n_results, out_data.out_valid, want.out_valid));
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                  n_results, out_data.status, want.status));
        if (out_data.copy_pending !== want.copy_pending)
          flag_mismatch($sformatf("result %0d copy_pending %b, want %b",
                                  n_results, out_data.copy_pending, want.copy_pending));
        if (out_data.seq_end !== want.seq_end)
          flag_mismatch($sformatf("result %0d seq_end %b, want %b",
                                  n_results, out_data.seq_end, want.seq_end));
      end
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      w = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      recv_wait <= w;
      out_ready <= (w == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r, lits, mlen, d, avail;

    // directed
    add_item(CMD_PULL, 8'h00, 1'b1, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b1, 1'b0);
    // three literals, empty match with ignored offset
    add_item(CMD_BYTE, 8'h30, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'hFF, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'hA5, 1'b1, 1'b0);
    // one literal then overlapping copy at distance 1, last flag before the copy
    add_item(CMD_BYTE, 8'h14, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h01, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h5A, 1'b1, 1'b0);
    add_item(CMD_BYTE, 8'hFF, 1'b1, 1'b0);
    repeat (4) add_item(CMD_PULL, 8'hFF, 1'b0, 1'b0);
    add_item(CMD_PULL, 8'h00, 1'b0, 1'b0);
    // offset past the history, then a zero offset
    add_item(CMD_BYTE, 8'h01, 1'b0, 1'b1);
    add_item(CMD_BYTE, 8'hFF, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'hFF, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h02, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    add_item(CMD_BYTE, 8'h00, 1'b0, 1'b0);
    hist_fill_est = 8;

    // long literal extension cut after two literals, long match extension dropped
    add_sequence(280, 2, $urandom_range(0, 65535), 1'b0, 6, 1'b1);
    add_sequence(0, 300, 0, 1'b0, -1, 1'b0);

    while (stream_q.size() < STREAM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        lits = pick_len(1'b0);
        mlen = pick_len(1'b0);
        avail = hist_fill_est + lits;
        if (avail > 65535) avail = 65535;
        if (avail == 0) mlen = 0;
        if (avail == 0) d = $urandom_range(0, 65535);
        else if ($urandom_range(0, 1) == 0) d = $urandom_range(1, (avail < 8) ? avail : 8);
        else d = $urandom_range(1, avail);
        add_sequence(lits, mlen, d, $urandom_range(0, 7) == 0, -1,
                     $urandom_range(0, 15) == 0);
      end else if (r < 80) begin
        add_sequence(pick_len(1'b1), pick_len(1'b1), $urandom_range(0, 65535), 1'b0, -2,
                     $urandom_range(0, 15) == 0);
      end else if (r < 87) begin
        avail = hist_fill_est + 1;
        lits = $urandom_range(0, 4);
        d = ($urandom_range(0, 3) == 0) ? 0 :
            $urandom_range((avail + lits < 65535) ? avail + lits : 65535, 65535);
        add_sequence(lits, (pick_len(1'b1) % 600) + 1, d, 1'b0, -1, 1'b0);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 2)) add_item(CMD_PULL, 8'($urandom), 1'($urandom), 1'b0);
      end else begin
        lits = $urandom_range(1, 6);
        for (int i = 0; i < lits; i++)
          add_item(CMD_BYTE, 8'($urandom), i == lits - 1, 1'b0);
        repeat (4) add_item(CMD_PULL, 8'($urandom), 1'($urandom), 1'b0);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (rst || stream_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (decoded_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", decoded_q.size()));

    $display("ran %0d stream transfers, %0d results checked, %0d sequences closed",
             n_sent, n_results, n_seq_end);
    $display("literals %0d, copied %0d, truncated %0d, bad offsets %0d, refused %0d, idle pulls %0d",
             n_literal, n_copied, n_trunc, n_badoff, n_refused, n_nopull);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lztsd_pkg.sv
rtl/lztsd_front.sv
rtl/lztsd_queue.sv
rtl/lztsd_back.sv
rtl/lz_token_sequence_decompressor.sv
tb/tb.sv
